// ===== hw/rtl/slt_pkg.sv =====
// shared types, codes and widths for the sorted list table
package slt_pkg;

  localparam int VAL_W        = 32;
  localparam int ACT_W        = 2;
  localparam int ST_W         = 3;
  localparam int POS_W        = 5;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 40;
  localparam int CAPACITY_DEF = 16;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_LIST   = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_INSERTED    = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL        = 3'd1;
  localparam logic [ST_W-1:0] ST_FOUND       = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [ST_W-1:0] ST_DELETED     = 3'd4;
  localparam logic [ST_W-1:0] ST_DEL_MISSING = 3'd5;
  localparam logic [ST_W-1:0] ST_LIST        = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic cap_en;      // capture the input transaction
    logic flag_en;     // register per-cell compare flags
    logic exec_en;     // apply insert/search/delete and load the result
    logic list_start;  // clear the list index
    logic list_en;     // emit one list entry and rotate the cells
  } slt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             count_zero;
    logic             out_free;
    logic             list_last;
  } slt_stat_t;

endpackage

// ===== hw/rtl/slt_ctrl.sv =====
// controller state machine for the sorted list table
module slt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  slt_pkg::slt_stat_t stat,
  output logic              in_ready,
  output slt_pkg::slt_cmd_t  cmd
);
  import slt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_LIST = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_en = 1'b1;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.flag_en = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (stat.act == ACT_LIST) begin
          cmd.list_start = 1'b1;
          state_nxt      = stat.count_zero ? S_IDLE : S_LIST;
        end else if (stat.out_free) begin
          cmd.exec_en = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.list_en = 1'b1;
          if (stat.list_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/slt_datapath.sv =====
// cell array, compare flags, entry count and result register
module slt_datapath #(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slt_pkg::slt_cmd_t                   cmd,
  output slt_pkg::slt_stat_t                  stat,
  input  logic        [slt_pkg::ACT_W-1:0]    in_action,
  input  logic signed [slt_pkg::VAL_W-1:0]    in_value,
  input  logic                                out_tready,
  output logic                                out_valid,
  output logic        [slt_pkg::ST_W-1:0]     out_status,
  output logic        [slt_pkg::POS_W-1:0]    out_position,
  output logic signed [slt_pkg::VAL_W-1:0]    out_value,
  output logic                                out_last
);
  import slt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic        [ACT_W-1:0]  act_r;
  logic signed [VAL_W-1:0]  val_r;
  logic signed [VAL_W-1:0]  cells_r   [CAPACITY];
  logic signed [VAL_W-1:0]  cells_nxt [CAPACITY];
  logic [CAPACITY-1:0]      lt_r, le_r, eq_r;
  logic [CAPACITY-1:0]      lt_nxt, le_nxt, eq_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         list_idx_r;
  logic [CNT_W-1:0]         last_idx;
  logic [CNT_W-1:0]         cnt_le;
  logic [CNT_W-1:0]         list_pos;
  logic [CAPACITY:0]        le_ext;
  logic [CAPACITY-1:0]      le_edge;
  logic [CNT_W+POS_W-1:0]   pos_ext;
  logic [CNT_W+POS_W-1:0]   list_pos_ext;
  logic                     full, hit;
  logic                     do_ins, do_del;

  logic                     out_valid_r;
  logic [ST_W-1:0]          out_status_r;
  logic [POS_W-1:0]         out_position_r;
  logic signed [VAL_W-1:0]  out_value_r;
  logic                     out_last_r;

  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign hit      = |eq_r;
  assign do_ins   = cmd.exec_en && (act_r == ACT_INSERT) && !full;
  assign do_del   = cmd.exec_en && (act_r == ACT_DELETE) && hit;
  assign last_idx = cnt_r - 1'b1;
  assign list_pos = list_idx_r + 1'b1;

  // per-cell compares against the captured value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_nxt[i] = (CNT_W'(i) < cnt_r) && (cells_r[i] <  val_r);
      le_nxt[i] = (CNT_W'(i) < cnt_r) && (cells_r[i] <= val_r);
      eq_nxt[i] = (CNT_W'(i) < cnt_r) && (cells_r[i] == val_r);
    end
  end

  // count of entries not greater than value: the le flags form a thermometer
  always_comb begin
    le_ext  = {1'b0, le_r};
    cnt_le  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      le_edge[i] = le_ext[i] & ~le_ext[i+1];
      if (le_edge[i]) cnt_le = cnt_le | CNT_W'(i + 1);
    end
  end

  assign pos_ext      = {{POS_W{1'b0}}, cnt_le};
  assign list_pos_ext = {{POS_W{1'b0}}, list_pos};

  // cell next values: insert shifts right, delete shifts left, list rotates
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_comb begin
      cells_nxt[g] = cells_r[g];
      if (do_ins && !lt_r[g]) begin
        if (g == 0) begin
          cells_nxt[g] = val_r;
        end else begin
          cells_nxt[g] = lt_r[(g > 0) ? g - 1 : 0] ? val_r : cells_r[(g > 0) ? g - 1 : 0];
        end
      end else if (do_del && !lt_r[g]) begin
        if (g < CAPACITY - 1) cells_nxt[g] = cells_r[(g < CAPACITY - 1) ? g + 1 : g];
      end else if (cmd.list_en) begin
        if (CNT_W'(g) == last_idx) begin
          cells_nxt[g] = cells_r[0];
        end else if ((CNT_W'(g) < last_idx) && (g < CAPACITY - 1)) begin
          cells_nxt[g] = cells_r[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  // entry count update
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_ins) cnt_nxt = cnt_r + 1'b1;
    else if (do_del) cnt_nxt = cnt_r - 1'b1;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      act_r <= in_action;
      val_r <= in_value;
    end
    if (cmd.flag_en) begin
      lt_r <= lt_nxt;
      le_r <= le_nxt;
      eq_r <= eq_nxt;
    end
    for (int i = 0; i < CAPACITY; i++) cells_r[i] <= cells_nxt[i];
  end

  // control registers: count and list index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      list_idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.list_start) list_idx_r <= '0;
      else if (cmd.list_en) list_idx_r <= list_pos;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec_en || cmd.list_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.list_en) begin
      out_status_r   <= ST_LIST;
      out_position_r <= list_pos_ext[POS_W-1:0];
      out_value_r    <= cells_r[0];
      out_last_r     <= stat.list_last;
    end else if (cmd.exec_en) begin
      out_value_r    <= val_r;
      out_last_r     <= 1'b1;
      unique case (act_r)
        ACT_INSERT: begin
          out_status_r   <= full ? ST_FULL : ST_INSERTED;
          out_position_r <= '0;
        end
        ACT_SEARCH: begin
          out_status_r   <= hit ? ST_FOUND : ST_NOT_FOUND;
          out_position_r <= pos_ext[POS_W-1:0];
        end
        ACT_DELETE: begin
          out_status_r   <= hit ? ST_DELETED : ST_DEL_MISSING;
          out_position_r <= '0;
        end
        default: begin
          out_status_r   <= ST_LIST;
          out_position_r <= '0;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;

  // status to the controller
  assign stat.act        = act_r;
  assign stat.count_zero = (cnt_r == '0);
  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.list_last  = (list_pos == cnt_r);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_en || cmd.list_en) |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not grow the count");

  a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.list_en && stat.list_last) |=> (out_valid_r && out_last_r))
    else $error("final list entry not marked last");
`endif

endmodule

// ===== hw/rtl/sorted_list_table_top.sv =====
// top level of the sorted list table: stream ports around controller and datapath
// results: an input is captured in idle, compared, then loaded into the output register in execute once it is free
// insert, search and delete do not overlap (capture, compare, execute): a new input is taken only back in idle
// list of n entries: after compare, one entry per cycle while the output is free, as the cell row rotates
// reset clears the entry count, the controller state and the output valid; cells are undefined
module sorted_list_table_top #(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [slt_pkg::IN_TDATA_W-1:0]     in_tdata,   // value[31:0]
  input  logic [slt_pkg::ACT_W-1:0]          in_tuser,   // action[1:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [slt_pkg::OUT_TDATA_W-1:0]    out_tdata,  // position[4:0], entry_value[36:5], zero pad
  output logic [slt_pkg::ST_W-1:0]           out_tuser,  // status[2:0]
  output logic                               out_tlast
);
  import slt_pkg::*;

  slt_cmd_t           cmd;
  slt_stat_t          stat;
  logic               ctrl_ready;
  logic [POS_W-1:0]   position;
  logic signed [VAL_W-1:0] entry_value;

  assign in_tready = ctrl_ready;

  // idle state only advances on an accepted input transaction
  slt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .stat     (stat),
    .in_ready (ctrl_ready),
    .cmd      (cmd)
  );

  slt_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_action    (in_tuser),
    .in_value     (in_tdata[VAL_W-1:0]),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .out_status   (out_tuser),
    .out_position (position),
    .out_value    (entry_value),
    .out_last     (out_tlast)
  );

  // pack the result transaction
  assign out_tdata = {{(OUT_TDATA_W - VAL_W - POS_W){1'b0}}, entry_value, position};

endmodule

// ===== sim/sorted_list_table_top_tb.sv =====
// testbench for the sorted list table: directed and random stream traffic checked against a software table
`timescale 1ns / 1ps

module sorted_list_table_top_tb;
  import slt_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int IDLE_PCT   = 28;
  localparam int CYCLE_CAP  = 300000;
  localparam int PRINT_CAP  = 40;
  localparam int N_RANDOM   = 330;
  localparam int PHASE_LEN  = 30;
  localparam logic signed [VAL_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] MAX_VAL = 32'sh7fff_ffff;

  typedef struct {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    bit                      hold;    // wait for the table to go quiet before sending
  } table_op_t;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } table_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [ACT_W-1:0] in_tuser = ACT_INSERT;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ST_W-1:0] out_tuser;
  logic out_tlast;

  table_op_t  op_queue[$];
  table_res_t expected_results[$];

  // software copy of the sorted table
  logic signed [VAL_W-1:0] shadow_cells[CAP];
  int shadow_count = 0;

  logic signed [VAL_W-1:0] value_pool[8];
  int sent_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  bit calm;

  sorted_list_table_top #(.CAPACITY(CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // value[31:0]
    .in_tuser   (in_tuser),   // action[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // position[4:0], entry_value[36:5], zero pad
    .out_tuser  (out_tuser),  // status[2:0]
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // a stretch of traffic with no idling on either side
  assign calm = (sent_count >= 150) && (sent_count < 230);

  function automatic void push_result(logic [ST_W-1:0] st, int pos,
                                      logic signed [VAL_W-1:0] v, logic lst);
    table_res_t r;
    r.status      = st;
    r.position    = pos[POS_W-1:0];
    r.entry_value = v;
    r.last        = lst;
    expected_results.push_back(r);
  endfunction

  // apply one operation to the shadow table and queue the results it causes
  function automatic void apply_table_op(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] v);
    int i;
    int j;
    int cnt;
    bit hit;
    case (act)
      ACT_INSERT: begin
        if (shadow_count >= CAP) begin
          push_result(ST_FULL, 0, v, 1'b1);
        end else begin
          i = 0;
          while (i < shadow_count && shadow_cells[i] < v) i++;
          for (j = shadow_count; j > i; j--) shadow_cells[j] = shadow_cells[j-1];
          shadow_cells[i] = v;
          shadow_count++;
          push_result(ST_INSERTED, 0, v, 1'b1);
        end
      end
      ACT_SEARCH: begin
        cnt = 0;
        hit = 1'b0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_cells[i] <= v) cnt++;
          if (shadow_cells[i] == v) hit = 1'b1;
        end
        push_result(hit ? ST_FOUND : ST_NOT_FOUND, cnt, v, 1'b1);
      end
      ACT_DELETE: begin
        i = 0;
        while (i < shadow_count && shadow_cells[i] != v) i++;
        if (i >= shadow_count) begin
          push_result(ST_DEL_MISSING, 0, v, 1'b1);
        end else begin
          for (j = i; j + 1 < shadow_count; j++) shadow_cells[j] = shadow_cells[j+1];
          shadow_count--;
          push_result(ST_DELETED, 0, v, 1'b1);
        end
      end
      ACT_LIST: begin
        for (i = 0; i < shadow_count; i++)
          push_result(ST_LIST, i + 1, shadow_cells[i], i == shadow_count - 1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (error_count < PRINT_CAP)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic void add_op(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] v,
                                 bit hold = 1'b0);
    table_op_t op;
    op.action = act;
    op.value  = v;
    op.hold   = hold;
    op_queue.push_back(op);
  endfunction

  // mostly values from a small pool so that searches and deletes hit
  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(99) < 75) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // driver: next operation goes out once the previous transaction is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (op_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
          !(op_queue[0].hold && (in_tvalid || expected_results.size() != 0))) begin
        in_tvalid <= 1'b1;
        in_tdata  <= op_queue[0].value;
        in_tuser  <= op_queue[0].action;
        void'(op_queue.pop_front());
        sent_count++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    table_res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) apply_table_op(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_tuser, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser != want.status)
            report_mismatch("status", out_tuser, want.status);
          if (out_tdata[POS_W-1:0] != want.position)
            report_mismatch("position", out_tdata[POS_W-1:0], want.position);
          if ($signed(out_tdata[POS_W+VAL_W-1:POS_W]) != want.entry_value)
            report_mismatch("entry_value", $signed(out_tdata[POS_W+VAL_W-1:POS_W]),
                            want.entry_value);
          if (out_tlast != want.last)
            report_mismatch("last", out_tlast, want.last);
          if (out_tdata[OUT_TDATA_W-1:POS_W+VAL_W] != '0)
            report_mismatch("tdata pad", out_tdata[OUT_TDATA_W-1:POS_W+VAL_W], 0);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int r;
    int k;
    bit filling;

    value_pool[0] = -2;
    value_pool[1] = -1;
    value_pool[2] = 0;
    value_pool[3] = 1;
    value_pool[4] = MIN_VAL;
    value_pool[5] = MAX_VAL;
    value_pool[6] = $urandom;
    value_pool[7] = $urandom;

    // empty table: list gives nothing, delete misses, search counts zero
    add_op(ACT_LIST, 0);
    add_op(ACT_DELETE, 0);
    add_op(ACT_SEARCH, 0);
    // extremes and duplicates
    add_op(ACT_INSERT, MIN_VAL);
    add_op(ACT_INSERT, MAX_VAL);
    add_op(ACT_INSERT, 0);
    add_op(ACT_INSERT, -1);
    add_op(ACT_INSERT, 5);
    add_op(ACT_INSERT, 5);
    add_op(ACT_INSERT, 1);
    add_op(ACT_SEARCH, 5);
    add_op(ACT_SEARCH, 3);
    add_op(ACT_SEARCH, MAX_VAL);
    add_op(ACT_SEARCH, MIN_VAL);
    add_op(ACT_DELETE, 5);
    add_op(ACT_DELETE, 7);
    add_op(ACT_LIST, $urandom);
    // fill to capacity, overflow once, then dump the full table
    for (k = 0; k < CAP - 6; k++) add_op(ACT_INSERT, $urandom);
    add_op(ACT_INSERT, MAX_VAL);
    add_op(ACT_LIST, 0);

    // random phases alternate between growing and shrinking the table
    for (k = 0; k < N_RANDOM; k++) begin
      filling = ((k / PHASE_LEN) % 2) == 0;
      r = $urandom_range(99);
      if (filling) begin
        if (r < 60)      add_op(ACT_INSERT, pick_value(), k == 0 || k == 160);
        else if (r < 75) add_op(ACT_SEARCH, pick_value(), k == 0 || k == 160);
        else if (r < 90) add_op(ACT_DELETE, pick_value(), k == 0 || k == 160);
        else             add_op(ACT_LIST, $urandom, k == 0 || k == 160);
      end else begin
        if (r < 15)      add_op(ACT_INSERT, pick_value(), k == 160);
        else if (r < 30) add_op(ACT_SEARCH, pick_value(), k == 160);
        else if (r < 90) add_op(ACT_DELETE, pick_value(), k == 160);
        else             add_op(ACT_LIST, $urandom, k == 160);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
